// ----- rtl/lsmp_pkg.sv -----
// shared types, constants and tables of the lidar sector minimum and projection core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lsmp_pkg;

    // scan bookkeeping
    localparam int MAX_SCAN_SAMPLES = 4096;
    localparam int CNT_W            = $clog2(MAX_SCAN_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SCAN_SAMPLES - 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FLOOR = 2'd2;
    localparam int START_W = 20;
    localparam int STEP_W  = 18;
    localparam int RANGE_W = 16;

    // angles, Q16 radians
    localparam int ANG_W   = 32;
    localparam int THETA_W = 20;
    localparam logic signed [ANG_W-1:0] Q16_PI_4  = 32'sd51472;
    localparam logic signed [ANG_W-1:0] Q16_3PI_4 = 32'sd154416;
    localparam logic signed [ANG_W-1:0] Q16_5PI_4 = 32'sd257359;
    localparam logic signed [ANG_W-1:0] Q16_7PI_4 = 32'sd360303;
    localparam logic signed [ANG_W-1:0] Q16_2PI   = 32'sd411775;

    // minima
    localparam int MIN_W = 17;
    localparam logic [MIN_W-1:0]   NONE_MIN    = 17'h1FFFF;
    localparam logic [RANGE_W-1:0] FRONT_LIMIT = 16'd650;

    // cordic, Q30
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = 5;
    localparam int CORD_W       = 34;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    // camera projection
    localparam int PROD_W = 51;
    localparam int CAM_W  = 20;
    localparam int NUM_W  = 49;
    localparam logic signed [PROD_W-1:0] CAM_Z_OFF = 51'sd19200;
    localparam logic signed [27:0] FX_Q16   = 28'sd55251761;
    localparam logic signed [27:0] CX_Q16   = 28'sd31351648;
    localparam logic signed [27:0] CY_Q16   = 28'sd21846445;
    localparam logic signed [NUM_W-1:0] FY_CAM_Y = NUM_W'(64'sd55327873 * 64'sd28672);
    localparam logic signed [27:0] LIM_U_Q  = 28'sd47185920;
    localparam logic signed [27:0] LIM_V_Q  = 28'sd62914560;
    localparam int PIX_W = 14;

    // divider
    localparam int DIV_W  = NUM_W - 1;
    localparam int DEN_W  = 32;
    localparam int QCNT_W = $clog2(PIX_W);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_CORDIC,
        ST_MUL,
        ST_CAM,
        ST_NUM,
        ST_CHECK,
        ST_DIVU,
        ST_DIVV,
        ST_POINT,
        ST_SUMMARY
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef struct packed {
        logic                      start;
        logic signed [THETA_W-1:0] theta;
    } t_cordic_req;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    // truncated arctangent table, Q30
    function automatic logic signed [CORD_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
        logic signed [CORD_W-1:0] v;
        unique case (i)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lsmp_cordic.sv -----
// iterative rotation cordic, one micro-rotation per cycle
// depends on lsmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsmp_cordic import lsmp_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cordic_req               i_req,
    output t_unit_stat                     o_stat,
    output logic signed [CORD_W-1:0]       o_cos,
    output logic signed [CORD_W-1:0]       o_sin
);

    logic signed [CORD_W-1:0] r_x, r_y, r_z;
    logic signed [CORD_W-1:0] w_xs, w_ys, w_atan;
    logic [ITER_W-1:0]        r_iter;
    logic                     r_busy, r_done;

    // shifted operands of this micro-rotation
    assign w_xs   = r_x >>> r_iter;
    assign w_ys   = r_y >>> r_iter;
    assign w_atan = atan_q30(r_iter);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_iter <= r_iter + 1'b1;
            end
        end
    end

    // rotation datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= CORDIC_GAIN_INV;
            r_y <= '0;
            r_z <= CORD_W'(i_req.theta) <<< 14;
        end else if (r_busy) begin
            if (!r_z[CORD_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_cos       = r_x;
    assign o_sin       = r_y;

endmodule

`default_nettype wire

// ----- rtl/lsmp_div.sv -----
// restoring divider, one quotient bit per cycle through shift registers
// depends on lsmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsmp_div import lsmp_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_div_req     i_req,
    output t_unit_stat        o_stat,
    output logic [PIX_W-1:0]  o_quot
);

    logic [DIV_W-1:0]  r_rem, r_den;
    logic [PIX_W-1:0]  r_quot;
    logic [QCNT_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic              w_fit;

    assign w_fit = (r_rem >= r_den);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == QCNT_W'(PIX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // divisor walks right, quotient bits shift in from the right
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= DIV_W'(i_req.den) << (PIX_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_den;
            end
            r_den  <= r_den >> 1;
            r_quot <= {r_quot[PIX_W-2:0], w_fit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

`default_nettype wire

// ----- rtl/lidar_sector_minimum_and_projection_core.sv -----
// top level: scan sequencer, sector minima, camera projection datapath
// depends on lsmp_pkg, lsmp_cordic, lsmp_div
//
// channel   direction  handshake              payload
// in        input      i_in_valid/o_in_stall  i_range_mm, i_range_valid, i_last_sample
// out       output     o_out_valid/i_out_stall o_result_kind .. o_last_result
// cfg       input      i_cfg_we               i_cfg_index, i_cfg_data
//
// a skipped or non-projected sample goes through the class state only, a summary adds
// the summary state; a projected sample runs the 16 cordic micro-rotations,
// 4 multiply and window stages, each of the two 14-bit serial divisions and
// the point load; a point outside the image ends after the window stages
// synchronous active-low reset restores register defaults and starts a new scan
// a result waits in the output register while out is stalled; no new sample is
// taken until all results of the current one are loaded
`timescale 1ns / 1ps
`default_nettype none

module lidar_sector_minimum_and_projection_core import lsmp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // samples
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [RANGE_W-1:0]    i_range_mm,
    input  wire logic                  i_range_valid,
    input  wire logic                  i_last_sample,
    // results
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_result_kind,
    output logic [PIX_W-1:0]           o_pixel_u,
    output logic [PIX_W-1:0]           o_pixel_v,
    output logic [RANGE_W-1:0]         o_front_min_mm,
    output logic                       o_front_found,
    output logic [RANGE_W-1:0]         o_all_min_mm,
    output logic                       o_any_found,
    output logic                       o_turn_left,
    output logic                       o_last_result
);

    t_state r_state, n_state;

    logic signed [START_W-1:0] r_angle_start;
    logic signed [STEP_W-1:0]  r_angle_step;
    logic [RANGE_W-1:0]        r_range_floor;

    logic [CNT_W-1:0]          r_cnt;
    logic [MIN_W-1:0]          r_front_min, r_all_min, r_left_min, r_right_min;

    logic [RANGE_W-1:0]        r_range;
    logic                      r_valid, r_last;
    logic signed [ANG_W-1:0]   r_angle;
    logic signed [STEP_W+CNT_W:0] w_step_prod;

    logic signed [PROD_W-1:0]  r_p_c, r_p_s;
    logic signed [CAM_W-1:0]   r_cam_x, r_cam_z;
    logic signed [NUM_W-1:0]   r_nu, r_nv, r_lim_u, r_lim_v;
    logic                      r_z_pos;
    logic [PIX_W-1:0]          r_pix_u;

    logic                      w_in_xfer, w_out_free;
    logic                      w_take, w_front, w_left, w_right, w_project, w_keep;

    t_cordic_req               w_cordic_req;
    t_unit_stat                w_cordic_stat;
    logic signed [CORD_W-1:0]  w_cos, w_sin;
    t_div_req                  w_div_req;
    t_unit_stat                w_div_stat;
    logic [PIX_W-1:0]          w_quot;

    // output register
    logic                      r_o_valid, r_o_kind, r_o_ffound, r_o_afound, r_o_turn, r_o_last;
    logic [PIX_W-1:0]          r_o_u, r_o_v;
    logic [RANGE_W-1:0]        r_o_fmin, r_o_amin;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_o_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // sample angle from the scan index
    assign w_step_prod = $signed({1'b0, r_cnt}) * r_angle_step;

    // sector classification
    assign w_take  = r_valid && (r_range >= r_range_floor);
    assign w_front = (r_angle > 0 && r_angle < Q16_PI_4) ||
                     (r_angle >= Q16_7PI_4 && r_angle <= Q16_2PI);
    assign w_left  = (r_angle > Q16_PI_4) && (r_angle < Q16_3PI_4);
    assign w_right = (r_angle > Q16_5PI_4) && (r_angle < Q16_7PI_4);
    assign w_project = w_take && w_front && (r_range < FRONT_LIMIT);

    // image window test
    assign w_keep = r_z_pos && !r_nu[NUM_W-1] && (r_nu < r_lim_u) &&
                    (r_nv > 0) && (r_nv < r_lim_v);

    // unit requests
    assign w_cordic_req.start = (r_state == ST_CLASS) && w_project;
    assign w_cordic_req.theta = (r_angle >= Q16_7PI_4) ? THETA_W'(r_angle - Q16_2PI)
                                                       : THETA_W'(r_angle);
    assign w_div_req.start = ((r_state == ST_CHECK) && w_keep) ||
                             ((r_state == ST_DIVU) && w_div_stat.done);
    assign w_div_req.num   = (r_state == ST_CHECK) ? r_nu[DIV_W-1:0] : r_nv[DIV_W-1:0];
    assign w_div_req.den   = {r_cam_z[DEN_W-13:0], 12'b0};

    lsmp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cordic_req),
        .o_stat  (w_cordic_stat),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    lsmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) n_state = ST_CLASS;
            end
            ST_CLASS: begin
                if (w_project)   n_state = ST_CORDIC;
                else if (r_last) n_state = ST_SUMMARY;
                else             n_state = ST_IDLE;
            end
            ST_CORDIC: begin
                if (w_cordic_stat.done) n_state = ST_MUL;
            end
            ST_MUL:   n_state = ST_CAM;
            ST_CAM:   n_state = ST_NUM;
            ST_NUM:   n_state = ST_CHECK;
            ST_CHECK: begin
                if (w_keep)      n_state = ST_DIVU;
                else if (r_last) n_state = ST_SUMMARY;
                else             n_state = ST_IDLE;
            end
            ST_DIVU: begin
                if (w_div_stat.done) n_state = ST_DIVV;
            end
            ST_DIVV: begin
                if (w_div_stat.done) n_state = ST_POINT;
            end
            ST_POINT: begin
                if (w_out_free) n_state = r_last ? ST_SUMMARY : ST_IDLE;
            end
            ST_SUMMARY: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start <= '0;
            r_angle_step  <= 18'sd1144;
            r_range_floor <= 16'd120;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ANGLE_START: r_angle_start <= i_cfg_data[START_W-1:0];
                CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_data[STEP_W-1:0];
                CFG_RANGE_FLOOR: r_range_floor <= i_cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // scan state: index and minima
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_front_min <= NONE_MIN;
            r_all_min   <= NONE_MIN;
            r_left_min  <= NONE_MIN;
            r_right_min <= NONE_MIN;
        end else if (r_state == ST_CLASS) begin
            if (r_cnt != CNT_MAX) r_cnt <= r_cnt + 1'b1;
            if (w_take) begin
                if (MIN_W'(r_range) < r_all_min) r_all_min <= MIN_W'(r_range);
                if (w_front && (r_range < FRONT_LIMIT)) begin
                    if (MIN_W'(r_range) < r_front_min) r_front_min <= MIN_W'(r_range);
                end else if (w_left) begin
                    if (MIN_W'(r_range) < r_left_min) r_left_min <= MIN_W'(r_range);
                end else if (w_right) begin
                    if (MIN_W'(r_range) < r_right_min) r_right_min <= MIN_W'(r_range);
                end
            end
        end else if (r_state == ST_SUMMARY && w_out_free) begin
            r_cnt       <= '0;
            r_front_min <= NONE_MIN;
            r_all_min   <= NONE_MIN;
            r_left_min  <= NONE_MIN;
            r_right_min <= NONE_MIN;
        end
    end

    // sample capture and projection datapath
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_range <= i_range_mm;
            r_valid <= i_range_valid;
            r_last  <= i_last_sample;
            r_angle <= ANG_W'(r_angle_start) + ANG_W'(w_step_prod);
        end
        if (r_state == ST_MUL) begin
            r_p_c <= $signed({1'b0, r_range}) * w_cos;
            r_p_s <= $signed({1'b0, r_range}) * w_sin;
        end
        if (r_state == ST_CAM) begin
            r_cam_x <= CAM_W'(-(r_p_s >>> 22));
            r_cam_z <= CAM_W'((r_p_c >>> 22) - CAM_Z_OFF);
        end
        // products formed at full numerator width
        if (r_state == ST_NUM) begin
            r_nu    <= FX_Q16 * NUM_W'(r_cam_x) + CX_Q16 * NUM_W'(r_cam_z);
            r_nv    <= FY_CAM_Y + CY_Q16 * NUM_W'(r_cam_z);
            r_lim_u <= LIM_U_Q * NUM_W'(r_cam_z);
            r_lim_v <= LIM_V_Q * NUM_W'(r_cam_z);
            r_z_pos <= (r_cam_z > 0);
        end
        if (r_state == ST_DIVU && w_div_stat.done) begin
            r_pix_u <= w_quot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == ST_POINT && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (r_state == ST_SUMMARY && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_POINT && w_out_free) begin
            r_o_kind   <= 1'b0;
            r_o_u      <= r_pix_u;
            r_o_v      <= w_quot;
            r_o_fmin   <= '0;
            r_o_ffound <= 1'b0;
            r_o_amin   <= '0;
            r_o_afound <= 1'b0;
            r_o_turn   <= 1'b0;
            r_o_last   <= !r_last;
        end else if (r_state == ST_SUMMARY && w_out_free) begin
            r_o_kind   <= 1'b1;
            r_o_u      <= '0;
            r_o_v      <= '0;
            r_o_fmin   <= (r_front_min != NONE_MIN) ? r_front_min[RANGE_W-1:0] : '0;
            r_o_ffound <= (r_front_min != NONE_MIN);
            r_o_amin   <= (r_all_min != NONE_MIN) ? r_all_min[RANGE_W-1:0] : '0;
            r_o_afound <= (r_all_min != NONE_MIN);
            r_o_turn   <= (r_right_min < r_left_min);
            r_o_last   <= 1'b1;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_result_kind  = r_o_kind;
    assign o_pixel_u      = r_o_u;
    assign o_pixel_v      = r_o_v;
    assign o_front_min_mm = r_o_fmin;
    assign o_front_found  = r_o_ffound;
    assign o_all_min_mm   = r_o_amin;
    assign o_any_found    = r_o_afound;
    assign o_turn_left    = r_o_turn;
    assign o_last_result  = r_o_last;

`ifndef SYNTHESIS
    // the two iterative units never run together
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cordic_stat.busy && w_div_stat.busy))
        else $error("cordic and divider busy together");

    // a transferred sample holds off the next one
    a_one_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_in_stall)
        else $error("sample taken while one is in work");

    // a summary is always the final result of its sample
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind) |-> o_last_result)
        else $error("summary without last flag");

    // projected points stay inside the image window
    a_point_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_result_kind) |-> (o_pixel_u < 14'd11520 && o_pixel_v < 14'd15360))
        else $error("point outside image");
`endif

endmodule

`default_nettype wire
